### hw/rtl/append_only_key_value_store_unit_macros.svh
// Assertion macros for the append-only key/value store.
// Used by the top level; expects clk and rst_n in scope.
`ifndef APPEND_ONLY_KEY_VALUE_STORE_UNIT_MACROS_SVH
`define APPEND_ONLY_KEY_VALUE_STORE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define AOKV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define AOKV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/aokv_pkg.sv
// Shared types and codes for the append-only key/value store.
// No dependencies.
`default_nettype none

package aokv_pkg;

  // Operation codes carried on the kind field
  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_GET   = 2'd1;
  localparam logic [1:0] KIND_ERASE = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  // djb2 seed
  localparam logic [31:0] HASH_SEED = 32'd5381;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INVAL,
    ST_APPEND,
    ST_RESP
  } aokv_state_t;

endpackage

`default_nettype wire

### hw/rtl/aokv_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module aokv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/append_only_key_value_store_unit.sv
// Append-only key/value store: key bytes are hashed as they arrive. A get scans the
// filled entries in order until a committed entry with the key's hash hits, or
// answers not found after the last filled entry; a get on an empty store answers
// without a scan. A set runs the same scan, invalidates an older copy of the key
// if one is found, and then appends; on an empty store it appends at once, and
// on a full store it answers full without a scan. The input reopens when the
// result is loaded, and a stalled result holds the input off. The lookup scan
// reads one entry per cycle from the entry memory. Erase answers without a scan
// and kind three is dropped; erase just clears the fill count, so there is no
// clearing pass after reset or erase. One operation runs at a time.
// Depends on aokv_pkg, aokv_ram and the assertion macro header.
`default_nettype none

`include "append_only_key_value_store_unit_macros.svh"

module append_only_key_value_store_unit #(
  parameter int ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [7:0]  in_key_byte,
  input  wire logic        in_key_last,
  input  wire logic [31:0] in_value,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [31:0]      out_read_value,
  output logic [7:0]       out_slot
);

  localparam int AW = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST_FREE = AW'(ENTRIES - 1);

  // Control registers
  aokv_pkg::aokv_state_t state_r, state_nxt;
  logic [AW-1:0] fill_r, fill_nxt;
  logic [31:0]   hash_accum_r, hash_accum_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          rdv_r, rdv_nxt;

  // Operation payload registers
  logic [31:0]   key_hash_r, key_hash_nxt;
  logic [31:0]   value_r, value_nxt;
  logic          op_set_r, op_set_nxt;
  logic          found_r, found_nxt;
  logic [AW-1:0] where_r, where_nxt;
  logic [AW-1:0] iss_r, iss_nxt;
  logic [AW-1:0] ridx_r, ridx_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic [31:0]   res_value_r, res_value_nxt;
  logic [AW-1:0] res_slot_r, res_slot_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [31:0]   out_value_r, out_value_nxt;
  logic [7:0]    out_slot_r, out_slot_nxt;

  // Memory ports
  logic          main_we;
  logic [63:0]   main_rdata;
  logic          mark_we;
  logic [AW-1:0] mark_waddr;
  logic          mark_wdata;
  logic          mark_rdata;

  // Handshake and decode
  logic        in_fire, out_free, is_full, fill_empty;
  logic        op_key, scan_hit, scan_miss;
  logic [31:0] hash_in;

  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != aokv_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign in_fire    = in_valid && !in_stall;
  assign is_full    = (fill_r == LAST_FREE);
  assign fill_empty = (fill_r == '0);
  assign op_key     = in_key_last &&
                      ((in_kind == aokv_pkg::KIND_SET) || (in_kind == aokv_pkg::KIND_GET));

  // djb2 step: h*33 + byte
  assign hash_in = (hash_accum_r << 5) + hash_accum_r + {24'd0, in_key_byte};

  // Scan compare on the entry read last cycle
  assign scan_hit  = rdv_r && mark_rdata && (main_rdata[63:32] == key_hash_r);
  assign scan_miss = rdv_r && !scan_hit && (ridx_r == fill_r - AW'(1));

  // Entry memory: {hash, data}; check byte always agrees with data, not kept
  aokv_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_main_ram (
    .clk   (clk),
    .we    (main_we),
    .waddr (fill_r),
    .wdata ({key_hash_r, value_r}),
    .raddr (iss_r),
    .rdata (main_rdata)
  );

  // Commit mark memory: 1 committed, 0 invalidated
  aokv_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (iss_r),
    .rdata (mark_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aokv_pkg::ST_IDLE: begin
        if (in_fire && op_key) begin
          priority if (in_kind == aokv_pkg::KIND_SET && is_full) begin
            state_nxt = aokv_pkg::ST_RESP;
          end else if (fill_empty) begin
            state_nxt = (in_kind == aokv_pkg::KIND_SET) ? aokv_pkg::ST_APPEND
                                                        : aokv_pkg::ST_RESP;
          end else begin
            state_nxt = aokv_pkg::ST_SCAN;
          end
        end
      end
      aokv_pkg::ST_SCAN: begin
        if (scan_hit) begin
          state_nxt = op_set_r ? aokv_pkg::ST_INVAL : aokv_pkg::ST_RESP;
        end else if (scan_miss) begin
          state_nxt = op_set_r ? aokv_pkg::ST_APPEND : aokv_pkg::ST_RESP;
        end
      end
      aokv_pkg::ST_INVAL:  state_nxt = aokv_pkg::ST_APPEND;
      aokv_pkg::ST_APPEND: state_nxt = aokv_pkg::ST_RESP;
      aokv_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = aokv_pkg::ST_IDLE;
        end
      end
      default: state_nxt = aokv_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    fill_nxt       = fill_r;
    hash_accum_nxt = hash_accum_r;
    rdv_nxt        = 1'b0;
    key_hash_nxt   = key_hash_r;
    value_nxt      = value_r;
    op_set_nxt     = op_set_r;
    found_nxt      = found_r;
    where_nxt      = where_r;
    iss_nxt        = iss_r;
    ridx_nxt       = ridx_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_slot_nxt   = res_slot_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_slot_nxt   = out_slot_r;
    out_valid_nxt  = out_valid_r && out_stall;
    main_we        = 1'b0;
    mark_we        = 1'b0;
    mark_waddr     = fill_r;
    mark_wdata     = 1'b0;

    unique case (state_r)
      aokv_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (in_kind)
            aokv_pkg::KIND_ERASE: begin
              fill_nxt       = '0;
              hash_accum_nxt = aokv_pkg::HASH_SEED;
              out_valid_nxt  = 1'b1;
              out_status_nxt = aokv_pkg::STATUS_OK;
              out_value_nxt  = '0;
              out_slot_nxt   = '0;
            end
            aokv_pkg::KIND_SET, aokv_pkg::KIND_GET: begin
              if (!in_key_last) begin
                hash_accum_nxt = hash_in;
              end else begin
                hash_accum_nxt = aokv_pkg::HASH_SEED;
                key_hash_nxt   = hash_in;
                value_nxt      = in_value;
                op_set_nxt     = (in_kind == aokv_pkg::KIND_SET);
                found_nxt      = 1'b0;
                iss_nxt        = '0;
                res_value_nxt  = '0;
                res_slot_nxt   = '0;
                res_status_nxt = aokv_pkg::STATUS_NOT_FOUND;
                if (in_kind == aokv_pkg::KIND_SET && is_full) begin
                  res_status_nxt = aokv_pkg::STATUS_FULL;
                end
              end
            end
            default: begin
              // kind three: dropped
            end
          endcase
        end
      end
      aokv_pkg::ST_SCAN: begin
        priority if (scan_hit) begin
          found_nxt      = 1'b1;
          where_nxt      = ridx_r;
          res_status_nxt = aokv_pkg::STATUS_OK;
          res_value_nxt  = main_rdata[31:0];
          res_slot_nxt   = ridx_r;
        end else if (!scan_miss) begin
          // keep issuing reads, one entry per cycle
          rdv_nxt  = 1'b1;
          ridx_nxt = iss_r;
          iss_nxt  = iss_r + AW'(1);
        end else begin
          // last filled entry missed; status stays not found
        end
      end
      aokv_pkg::ST_INVAL: begin
        mark_we    = 1'b1;
        mark_waddr = where_r;
        mark_wdata = 1'b0;
      end
      aokv_pkg::ST_APPEND: begin
        main_we        = 1'b1;
        mark_we        = 1'b1;
        mark_waddr     = fill_r;
        mark_wdata     = 1'b1;
        fill_nxt       = fill_r + AW'(1);
        res_status_nxt = aokv_pkg::STATUS_OK;
        res_value_nxt  = '0;
        res_slot_nxt   = fill_r;
      end
      aokv_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_slot_nxt   = 8'(res_slot_r);
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= aokv_pkg::ST_IDLE;
      fill_r       <= '0;
      hash_accum_r <= aokv_pkg::HASH_SEED;
      out_valid_r  <= 1'b0;
      rdv_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      hash_accum_r <= hash_accum_nxt;
      out_valid_r  <= out_valid_nxt;
      rdv_r        <= rdv_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_hash_r   <= key_hash_nxt;
    value_r      <= value_nxt;
    op_set_r     <= op_set_nxt;
    found_r      <= found_nxt;
    where_r      <= where_nxt;
    iss_r        <= iss_nxt;
    ridx_r       <= ridx_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_value_r;
  assign out_slot       = out_slot_r;

  // Checks
  `AOKV_ASSERT_NEXT(a_append_bumps_fill, state_r == aokv_pkg::ST_APPEND,
                    fill_r == $past(fill_r) + AW'(1), "append did not bump fill count")
  `AOKV_ASSERT_SAME(a_inval_only_set_hit, state_r == aokv_pkg::ST_INVAL,
                    op_set_r && found_r, "invalidate without a set hit")
  `AOKV_ASSERT_NEXT(a_resp_loads_out, state_r == aokv_pkg::ST_RESP && out_free,
                    out_valid_r && state_r == aokv_pkg::ST_IDLE, "response not delivered")
  `AOKV_ASSERT_SAME(a_no_write_in_scan, state_r == aokv_pkg::ST_SCAN,
                    !main_we && !mark_we, "memory write during scan")

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the append-only key/value store: a queue-fed driver,
// a clocked monitor and a built-in store predictor compare every result in order.
// Depends on aokv_pkg and append_only_key_value_store_unit.
`default_nettype none

module tb;

  localparam int          N_ENTRIES     = 256;
  localparam int          KEY_POOL      = 12;
  localparam int          SETTLE_CYCLES = 300;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam logic [1:0]  KIND_IGNORED  = 2'd3;

  typedef enum logic [1:0] {
    MARK_ERASED,
    MARK_COMMITTED,
    MARK_INVALID
  } mark_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [31:0] value;
  } op_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [7:0]  slot;
  } kv_result_t;

  // key bytes packed low byte first
  typedef struct {
    int          len;
    logic [31:0] bytes;
  } key_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = aokv_pkg::KIND_SET;
  logic [7:0]  in_key_byte = 8'd0;
  logic        in_key_last = 1'b0;
  logic [31:0] in_value = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_read_value;
  logic [7:0]  out_slot;

  append_only_key_value_store_unit #(.ENTRIES(N_ENTRIES)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_key_byte    (in_key_byte),
    .in_key_last    (in_key_last),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_slot       (out_slot)
  );

  always #5 clk = ~clk;

  // Predicted store contents
  logic [31:0] ent_hash [N_ENTRIES];
  logic [31:0] ent_data [N_ENTRIES];
  logic [7:0]  ent_check [N_ENTRIES];
  mark_t       ent_mark [N_ENTRIES];
  int unsigned fill;
  logic [31:0] hash_run;

  op_item_t    stim_q[$];
  kv_result_t  result_q[$];
  key_t        key_pool [KEY_POOL];

  int   n_queued;
  int   mismatches;
  int   cycle_count;
  int   n_set, n_full, n_hit, n_miss, n_erase;
  bit   in_took, out_took;
  bit   calm = 1'b0;
  int   send_wait, recv_wait;

  function automatic logic [7:0] check_byte(logic [31:0] v);
    return v[7:0] ^ v[15:8] ^ v[23:16] ^ v[31:24];
  endfunction

  function automatic void wipe_store();
    for (int i = 0; i < N_ENTRIES; i++) begin
      ent_hash[i]  = '1;
      ent_data[i]  = '1;
      ent_check[i] = '1;
      ent_mark[i]  = MARK_ERASED;
    end
    fill = 0;
  endfunction

  // First committed entry with matching hash and consistent check byte
  function automatic bit find_live(input logic [31:0] h, output int slot);
    int lim;
    lim  = (fill < N_ENTRIES) ? fill : N_ENTRIES;
    slot = 0;
    for (int i = 0; i < lim; i++) begin
      if (ent_mark[i] == MARK_COMMITTED && ent_hash[i] == h &&
          check_byte(ent_data[i]) == ent_check[i]) begin
        slot = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Apply one accepted transaction to the predicted store
  function automatic void store_step(logic [1:0] kind, logic [7:0] kb, logic k_last,
                                     logic [31:0] val);
    logic [31:0] h;
    int          slot;
    kv_result_t  r;
    r = '{status: aokv_pkg::STATUS_OK, read_value: 32'd0, slot: 8'd0};
    if (kind == KIND_IGNORED) return;
    if (kind == aokv_pkg::KIND_ERASE) begin
      wipe_store();
      hash_run = aokv_pkg::HASH_SEED;
      n_erase++;
      result_q.push_back(r);
      return;
    end
    h = (hash_run << 5) + hash_run + {24'd0, kb};
    if (!k_last) begin
      hash_run = h;
      return;
    end
    hash_run = aokv_pkg::HASH_SEED;
    if (kind == aokv_pkg::KIND_GET) begin
      if (find_live(h, slot)) begin
        r.read_value = ent_data[slot];
        r.slot       = slot[7:0];
        n_hit++;
      end else begin
        r.status = aokv_pkg::STATUS_NOT_FOUND;
        n_miss++;
      end
    end else if (fill >= N_ENTRIES - 1) begin
      r.status = aokv_pkg::STATUS_FULL;
      n_full++;
    end else begin
      if (find_live(h, slot)) ent_mark[slot] = MARK_INVALID;
      slot            = fill;
      ent_hash[slot]  = h;
      ent_data[slot]  = val;
      ent_check[slot] = check_byte(val);
      ent_mark[slot]  = MARK_COMMITTED;
      fill++;
      r.slot = slot[7:0];
      n_set++;
    end
    result_q.push_back(r);
  endfunction

  function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Monitor: predict on accepted inputs, then check accepted results
  always @(posedge clk) begin
    kv_result_t want;
    bit         ok;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("append_only_key_value_store_unit regression: fail");
      $finish;
    end else if (!rst_n) begin
      in_took  <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took  <= in_valid && !in_stall;
      out_took <= out_valid && !out_stall;
      if (in_valid && !in_stall) begin
        store_step(in_kind, in_key_byte, in_key_last, in_value);
        if ($urandom_range(0, 39) == 0) calm <= !calm;
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("result with none expected: status %0d value 0x%0h slot %0d",
                 out_status, out_read_value, out_slot);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          ok = field_ok("status", 32'(want.status), 32'(out_status));
          ok = field_ok("read_value", want.read_value, out_read_value) && ok;
          ok = field_ok("slot", 32'(want.slot), 32'(out_slot)) && ok;
          if (!ok) mismatches++;
        end
      end
    end
  end

  // Driver: present queued transactions with random gaps before each
  always @(negedge clk) begin
    op_item_t it;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait = 0;
    end else if (!in_valid || in_took) begin
      if (in_valid && in_took) send_wait = calm ? 0 : $urandom_range(0, 10);
      if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (stim_q.size() != 0) begin
        it = stim_q.pop_front();
        in_kind     <= it.kind;
        in_key_byte <= it.key_byte;
        in_key_last <= it.key_last;
        in_value    <= it.value;
        in_valid    <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side back-pressure: a random stall after each result
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_took) recv_wait = calm ? 0 : $urandom_range(0, 10);
      else if (recv_wait > 0) recv_wait--;
      out_stall <= (recv_wait != 0);
    end
  end

  function automatic logic [31:0] rand_value();
    unique case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_item(logic [1:0] kind, logic [7:0] kb, logic k_last, logic [31:0] val);
    op_item_t it;
    it = '{kind: kind, key_byte: kb, key_last: k_last, value: val};
    stim_q.push_back(it);
    n_queued++;
  endtask

  // Stream a key; the leading bytes carry lead_kind, the final byte end_kind
  task automatic push_key(logic [1:0] lead_kind, logic [1:0] end_kind, key_t k,
                          logic [31:0] val);
    for (int i = 0; i < k.len - 1; i++)
      push_item(lead_kind, k.bytes[8*i +: 8], 1'b0, rand_value());
    push_item(end_kind, k.bytes[8*(k.len-1) +: 8], 1'b1, val);
  endtask

  task automatic settle();
    while (stim_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed gets and sets on a small key pool, with some noise
  task automatic random_ops(int upto);
    int         r;
    key_t       k;
    logic [1:0] lead;
    while (n_queued < upto) begin
      r = $urandom_range(0, 99);
      k = key_pool[$urandom_range(0, KEY_POOL - 1)];
      lead = 2'($urandom_range(0, 1));
      if (r < 44) begin
        push_key(($urandom_range(0, 7) == 0) ? lead : aokv_pkg::KIND_SET,
                 aokv_pkg::KIND_SET, k, rand_value());
      end else if (r < 88) begin
        push_key(($urandom_range(0, 7) == 0) ? lead : aokv_pkg::KIND_GET,
                 aokv_pkg::KIND_GET, k, rand_value());
      end else if (r < 91) begin
        push_item(aokv_pkg::KIND_ERASE, 8'($urandom), 1'($urandom), rand_value());
      end else if (r < 94) begin
        push_item(KIND_IGNORED, 8'($urandom), 1'($urandom), rand_value());
      end else begin
        // stray leading bytes that prefix the next key
        repeat ($urandom_range(1, 2))
          push_item(2'($urandom_range(0, 1)), 8'($urandom), 1'b0, rand_value());
      end
    end
  endtask

  initial begin
    key_t k;
    wipe_store();
    hash_run = aokv_pkg::HASH_SEED;
    for (int i = 0; i < KEY_POOL; i++) begin
      key_pool[i].len   = $urandom_range(1, 3);
      key_pool[i].bytes = $urandom;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty miss, extremes, hash collision, zero byte, overwrite
    push_key(aokv_pkg::KIND_GET, aokv_pkg::KIND_GET, '{len: 1, bytes: 32'h01}, 32'd0);
    push_key(aokv_pkg::KIND_SET, aokv_pkg::KIND_SET, '{len: 1, bytes: 32'hFF},
             32'hFFFF_FFFF);
    push_key(aokv_pkg::KIND_GET, aokv_pkg::KIND_GET, '{len: 1, bytes: 32'hFF}, 32'd0);
    // mixed kinds: the last byte's kind wins
    push_key(aokv_pkg::KIND_GET, aokv_pkg::KIND_SET, '{len: 2, bytes: 32'h6241}, 32'd0);
    // different key, same djb2 hash
    push_key(aokv_pkg::KIND_GET, aokv_pkg::KIND_GET, '{len: 2, bytes: 32'h4142}, 32'd0);
    push_key(aokv_pkg::KIND_SET, aokv_pkg::KIND_SET, '{len: 1, bytes: 32'h00},
             32'h1234_5678);
    // second set of a key retires the first copy
    push_key(aokv_pkg::KIND_SET, aokv_pkg::KIND_SET, '{len: 1, bytes: 32'hFF},
             32'h0000_FFFF);
    push_key(aokv_pkg::KIND_GET, aokv_pkg::KIND_GET, '{len: 1, bytes: 32'hFF}, 32'd0);
    // ignored kind in the middle of a key
    push_item(aokv_pkg::KIND_SET, 8'h80, 1'b0, 32'h8000_0001);
    push_item(KIND_IGNORED, 8'h33, 1'b1, 32'hFFFF_FFFF);
    push_item(aokv_pkg::KIND_GET, 8'h7F, 1'b1, 32'd0);
    // erase without key_last drops a partial key
    push_item(aokv_pkg::KIND_SET, 8'h10, 1'b0, 32'h5555_5555);
    push_item(aokv_pkg::KIND_ERASE, 8'hC3, 1'b0, 32'hAAAA_AAAA);
    push_key(aokv_pkg::KIND_GET, aokv_pkg::KIND_GET, '{len: 1, bytes: 32'hFF}, 32'd0);
    push_item(aokv_pkg::KIND_ERASE, 8'h00, 1'b1, 32'd0);
    push_key(aokv_pkg::KIND_SET, aokv_pkg::KIND_SET, '{len: 4, bytes: 32'h01FF_55AA},
             32'hA5A5_A5A5);
    push_key(aokv_pkg::KIND_SET, aokv_pkg::KIND_GET, '{len: 4, bytes: 32'h01FF_55AA},
             32'd0);
    settle();

    random_ops(160);
    settle();

    // Fill to the full mark, then hit the full case and a worst-case scan
    push_item(aokv_pkg::KIND_ERASE, 8'h5A, 1'b1, 32'd0);
    for (int i = 0; i < N_ENTRIES - 1; i++)
      push_key(aokv_pkg::KIND_SET, aokv_pkg::KIND_SET,
               '{len: 1, bytes: 32'($urandom)}, rand_value());
    k = '{len: 1, bytes: 32'hA7};
    push_key(aokv_pkg::KIND_SET, aokv_pkg::KIND_SET, k, 32'h0BAD_F00D);
    push_key(aokv_pkg::KIND_GET, aokv_pkg::KIND_GET, k, 32'd0);
    push_key(aokv_pkg::KIND_GET, aokv_pkg::KIND_GET, '{len: 3, bytes: 32'h00F0_0FF0},
             32'd0);
    push_item(aokv_pkg::KIND_ERASE, 8'hFF, 1'b0, 32'd0);
    settle();

    random_ops(550);
    settle();

    if (result_q.size() != 0) begin
      $error("%0d expected results never arrived", result_q.size());
      mismatches++;
    end
    $display("ran %0d transactions: %0d sets, %0d full, %0d get hits, %0d get misses,",
             n_queued, n_set, n_full, n_hit, n_miss);
    $display("%0d erases, %0d mismatches in %0d cycles", n_erase, mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("append_only_key_value_store_unit regression: pass");
    end else begin
      $display("append_only_key_value_store_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

### append_only_key_value_store_unit.f
+incdir+hw/rtl
hw/rtl/aokv_pkg.sv
hw/rtl/aokv_ram.sv
hw/rtl/append_only_key_value_store_unit.sv
tb/tb.sv
